// File: rtl/mrpt_pkg.sv
// Package for the Miller-Rabin primality test block.
// Holds controller/datapath command and status types and the witness table.
`default_nettype none
package mrpt_pkg;

  localparam int unsigned NumW = 64;
  localparam int unsigned ShW  = 6;

  // witness count cap; larger round settings saturate here
  localparam logic [3:0]  MaxWit = 4'd12;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CLASSIFY,
    ST_STRIP,
    ST_WIT,
    ST_POW_STEP,
    ST_MUL,
    ST_CHECK,
    ST_SQR_LOOP,
    ST_DONE
  } mrpt_state_e;

  // multiplier operand select
  typedef enum logic [1:0] {
    MS_ACC_B,
    MS_B_B,
    MS_X_X
  } mrpt_msel_e;

  typedef struct packed {
    logic       load;
    logic       strip;
    logic       wit_load;
    logic       mul_start;
    mrpt_msel_e mul_sel;
    logic       pow_next;
    logic       res_set;
    logic       res_val;
  } mrpt_cmd_t;

  typedef struct packed {
    logic       small_lt2;
    logic       small_2_3;
    logic       even;
    logic       d_odd;
    logic       e_zero;
    logic       e_lsb;
    logic       mul_busy;
    logic       wit_ge_n;
    logic       x_is_one;
    logic       x_is_nm1;
    logic       j_done;
    logic       sq_first;
  } mrpt_sts_t;

  function automatic logic [5:0] wit_value(input logic [3:0] idx);
    logic [5:0] v;
    case (idx)
      4'd0:    v = 6'd2;
      4'd1:    v = 6'd3;
      4'd2:    v = 6'd5;
      4'd3:    v = 6'd7;
      4'd4:    v = 6'd11;
      4'd5:    v = 6'd13;
      4'd6:    v = 6'd17;
      4'd7:    v = 6'd19;
      4'd8:    v = 6'd23;
      4'd9:    v = 6'd29;
      4'd10:   v = 6'd31;
      4'd11:   v = 6'd37;
      default: v = 6'd2;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

// File: rtl/mrpt_mulmod.sv
// Bit-serial modular multiplier: (x*y) mod m, one bit of y per cycle.
// Depends on mrpt_pkg.
`default_nettype none
module mrpt_mulmod
  import mrpt_pkg::*;
(
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            start_i,
  input  wire logic [NumW-1:0] x_i,
  input  wire logic [NumW-1:0] y_i,
  input  wire logic [NumW-1:0] m_i,
  output logic                 busy_o,
  output logic [NumW-1:0]      p_o
);

  logic [NumW-1:0] acc_q, acc_d, y_q, x_q;
  logic [ShW-1:0]  cnt_q;
  logic            busy_q;
  logic [NumW:0]   dbl, s1, add1;
  logic [NumW-1:0] a1;

  // double then conditional add, each reduced with one compare/subtract
  always_comb begin
    dbl  = {acc_q, 1'b0};
    s1   = (dbl >= {1'b0, m_i}) ? dbl - {1'b0, m_i} : dbl;
    a1   = s1[NumW-1:0];
    add1 = {1'b0, a1} + {1'b0, x_q};
    if (y_q[NumW-1]) begin
      acc_d = (add1 >= {1'b0, m_i}) ? NumW'(add1 - {1'b0, m_i}) : add1[NumW-1:0];
    end else begin
      acc_d = a1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + 1'b1;
      if (cnt_q == ShW'(NumW - 1)) busy_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      acc_q <= '0;
      x_q   <= x_i;
      y_q   <= y_i;
    end else if (busy_q) begin
      acc_q <= acc_d;
      y_q   <= {y_q[NumW-2:0], 1'b0};
    end
  end

  assign busy_o = busy_q;
  assign p_o    = acc_q;

endmodule
`default_nettype wire

// File: rtl/mrpt_datapath.sv
// Datapath: n, d, r, exponent, base, accumulator, witness index, result.
// Depends on mrpt_pkg and mrpt_mulmod.
`default_nettype none
module mrpt_datapath
  import mrpt_pkg::*;
(
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic [NumW-1:0] number_i,
  input  wire logic [3:0]      rounds_i,
  input  wire mrpt_cmd_t       cmd_i,
  input  wire logic            cnt_ld_i,
  input  wire logic            cnt_inc_i,
  input  wire logic            sq_ld_i,
  input  wire logic            sq_inc_i,
  output mrpt_sts_t            sts_o,
  output logic                 wit_done_o,
  output logic                 res_o
);

  logic [NumW-1:0] n_q, d_q, e_q, b_q, acc_q, x_q;
  logic [ShW-1:0]  r_q, j_q;
  logic [3:0]      wi_q, cnt_lim;
  logic            res_q;
  logic [NumW-1:0] mx, my, prod, nm1;
  logic            busy;
  mrpt_msel_e      sel_q;

  assign nm1     = n_q - 1'b1;
  assign cnt_lim = (rounds_i > MaxWit) ? MaxWit : rounds_i;

  always_comb begin
    case (cmd_i.mul_sel)
      MS_ACC_B: begin mx = acc_q; my = b_q; end
      MS_B_B:   begin mx = b_q;   my = b_q; end
      MS_X_X:   begin mx = x_q;   my = x_q; end
      default:  begin mx = b_q;   my = b_q; end
    endcase
  end

  mrpt_mulmod u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(cmd_i.mul_start),
    .x_i    (mx),
    .y_i    (my),
    .m_i    (n_q),
    .busy_o (busy),
    .p_o    (prod)
  );

  // operand registers; product written back on pow_next / sq_inc
  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_start) sel_q <= cmd_i.mul_sel;
    if (cmd_i.load) begin
      n_q <= number_i;
      d_q <= number_i - 1'b1;
      r_q <= '0;
    end else if (cmd_i.strip) begin
      d_q <= {1'b0, d_q[NumW-1:1]};
      r_q <= r_q + 1'b1;
    end
    if (cmd_i.wit_load) begin
      b_q   <= NumW'(wit_value(wi_q));
      e_q   <= d_q;
      acc_q <= NumW'(1);
    end else if (cmd_i.pow_next) begin
      if (sel_q == MS_ACC_B) acc_q <= prod;
      else begin
        b_q <= prod;
        e_q <= {1'b0, e_q[NumW-1:1]};
      end
    end
    if (sq_ld_i) begin
      j_q <= ShW'(1);
      x_q <= acc_q;
    end else if (sq_inc_i) begin
      j_q <= j_q + 1'b1;
      x_q <= prod;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wi_q  <= '0;
      res_q <= 1'b0;
    end else begin
      if (cnt_ld_i) wi_q <= '0;
      else if (cnt_inc_i) wi_q <= wi_q + 1'b1;
      if (cmd_i.res_set) res_q <= cmd_i.res_val;
    end
  end

  assign sts_o.small_lt2 = (n_q < NumW'(2));
  assign sts_o.small_2_3 = (n_q == NumW'(2)) || (n_q == NumW'(3));
  assign sts_o.even      = ~n_q[0];
  assign sts_o.d_odd     = d_q[0];
  assign sts_o.e_zero    = (e_q == '0);
  assign sts_o.e_lsb     = e_q[0];
  assign sts_o.mul_busy  = busy;
  assign sts_o.wit_ge_n  = (NumW'(wit_value(wi_q)) >= n_q);
  assign sts_o.x_is_one  = (x_q == NumW'(1));
  assign sts_o.x_is_nm1  = (x_q == nm1);
  assign sts_o.j_done    = (j_q >= r_q);
  // x still holds the pow-mod result, no squaring done yet
  assign sts_o.sq_first  = (j_q == ShW'(1));
  assign wit_done_o      = (wi_q >= cnt_lim);
  assign res_o           = res_q;

endmodule
`default_nettype wire

// File: rtl/mrpt_ctrl.sv
// Controller state machine sequencing classification, pow-mod and squaring.
// Depends on mrpt_pkg.
`default_nettype none
module mrpt_ctrl
  import mrpt_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_ready_o,
  output logic           out_valid_o,
  input  wire logic      out_ready_i,
  input  wire mrpt_sts_t sts_i,
  input  wire logic      wit_done_i,
  output mrpt_cmd_t      cmd_o,
  output logic           cnt_ld_o,
  output logic           cnt_inc_o,
  output logic           sq_ld_o,
  output logic           sq_inc_o
);

  mrpt_state_e state_q, state_d;
  logic        sq_mode_q, sq_mode_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      sq_mode_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      sq_mode_q <= sq_mode_d;
    end
  end

  // next state and commands
  always_comb begin
    state_d     = state_q;
    sq_mode_d   = sq_mode_q;
    cmd_o       = '0;
    cmd_o.mul_sel = MS_B_B;
    cnt_ld_o    = 1'b0;
    cnt_inc_o   = 1'b0;
    sq_ld_o     = 1'b0;
    sq_inc_o    = 1'b0;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          cnt_ld_o   = 1'b1;
          state_d    = ST_CLASSIFY;
        end
      end
      ST_CLASSIFY: begin
        if (sts_i.small_lt2 || (sts_i.even && !sts_i.small_2_3)) begin
          cmd_o.res_set = 1'b1; cmd_o.res_val = 1'b0; state_d = ST_DONE;
        end else if (sts_i.small_2_3) begin
          cmd_o.res_set = 1'b1; cmd_o.res_val = 1'b1; state_d = ST_DONE;
        end else state_d = ST_STRIP;
      end
      ST_STRIP: begin
        if (sts_i.d_odd) state_d = ST_WIT;
        else cmd_o.strip = 1'b1;
      end
      ST_WIT: begin
        if (wit_done_i) begin
          cmd_o.res_set = 1'b1; cmd_o.res_val = 1'b1; state_d = ST_DONE;
        end else if (sts_i.wit_ge_n) cnt_inc_o = 1'b1;
        else begin
          cmd_o.wit_load = 1'b1; state_d = ST_POW_STEP;
        end
      end
      ST_POW_STEP: begin
        sq_mode_d = 1'b0;
        if (sts_i.e_zero) begin
          sq_ld_o = 1'b1; state_d = ST_CHECK;
        end else if (sts_i.e_lsb && !sq_mode_q) begin
          // multiply acc by base, then come back for the squaring
          cmd_o.mul_start = 1'b1; cmd_o.mul_sel = MS_ACC_B;
          sq_mode_d = 1'b1; state_d = ST_MUL;
        end else begin
          cmd_o.mul_start = 1'b1; cmd_o.mul_sel = MS_B_B;
          sq_mode_d = 1'b0; state_d = ST_MUL;
        end
      end
      ST_MUL: begin
        if (!sts_i.mul_busy) begin
          cmd_o.pow_next = 1'b1; state_d = ST_POW_STEP;
          sq_mode_d = sq_mode_q;
        end
      end
      ST_CHECK: begin
        // x == 1 passes only straight after pow-mod, n-1 passes at any step
        if ((sts_i.x_is_one && sts_i.sq_first) || sts_i.x_is_nm1) begin
          cnt_inc_o = 1'b1; state_d = ST_WIT;
        end else if (sts_i.j_done) begin
          cmd_o.res_set = 1'b1; cmd_o.res_val = 1'b0; state_d = ST_DONE;
        end else begin
          cmd_o.mul_start = 1'b1; cmd_o.mul_sel = MS_X_X; state_d = ST_SQR_LOOP;
        end
      end
      ST_SQR_LOOP: begin
        if (!sts_i.mul_busy) begin
          sq_inc_o = 1'b1; state_d = ST_CHECK;
        end
      end
      ST_DONE: begin
        out_valid_o = 1'b1;
        if (out_ready_i) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule
`default_nettype wire

// File: rtl/miller_rabin_primality_test_top.sv
// Top level of the 64-bit Miller-Rabin primality test.
// Depends on mrpt_pkg, mrpt_ctrl, mrpt_datapath, mrpt_mulmod.
//
//  channel  | handshake                    | payload
//  input    | number_valid_i/number_ready_o| number_i[63:0]
//  output   | result_valid_o/result_ready_i| prime_flag_o
//  config   | cfg_valid_i/cfg_ready_o      | cfg_data_i[3:0] witness_rounds
//
// One item at a time. Each modular product on the shared bit-serial unit
// takes a start, the shift/reduce steps and a write-back. An odd n needs
// at most about 2*64 products per witness. Even and tiny n finish without
// using the multiplier.
// Reset sets witness_rounds to 12.
// The result holds in DONE until taken; no new item is accepted meanwhile.
`default_nettype none
module miller_rabin_primality_test_top
  import mrpt_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [3:0]  cfg_data_i,
  input  wire logic        number_valid_i,
  output logic             number_ready_o,
  input  wire logic [63:0] number_i,
  output logic             result_valid_o,
  input  wire logic        result_ready_i,
  output logic             prime_flag_o
);

  mrpt_cmd_t  cmd;
  mrpt_sts_t  sts;
  logic [3:0] rounds_q;
  logic       wit_done, cnt_ld, cnt_inc, sq_ld, sq_inc;

  assign cfg_ready_o = 1'b1;

  // configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) rounds_q <= MaxWit;
    else if (cfg_valid_i) rounds_q <= cfg_data_i;
  end

  mrpt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (number_valid_i),
    .in_ready_o (number_ready_o),
    .out_valid_o(result_valid_o),
    .out_ready_i(result_ready_i),
    .sts_i      (sts),
    .wit_done_i (wit_done),
    .cmd_o      (cmd),
    .cnt_ld_o   (cnt_ld),
    .cnt_inc_o  (cnt_inc),
    .sq_ld_o    (sq_ld),
    .sq_inc_o   (sq_inc)
  );

  mrpt_datapath u_dp (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .number_i  (number_i),
    .rounds_i  (rounds_q),
    .cmd_i     (cmd),
    .cnt_ld_i  (cnt_ld),
    .cnt_inc_i (cnt_inc),
    .sq_ld_i   (sq_ld),
    .sq_inc_i  (sq_inc),
    .sts_o     (sts),
    .wit_done_o(wit_done),
    .res_o     (prime_flag_o)
  );

  // no input transfer while a result waits
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> !number_ready_o) else $error("ready while result pending");

  // a started product never overlaps a busy unit
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.mul_start |-> !sts.mul_busy) else $error("mulmod restarted while busy");

  // result stays stable while stalled
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && !result_ready_i |=> $stable(prime_flag_o))
    else $error("result changed during stall");

endmodule
`default_nettype wire
